>>> hw/rtl/sbldc_pkg.sv
package sbldc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int THRESH_W = 8;
    localparam int LIMIT_W  = 16;
    localparam int POS_W    = 3;
    localparam int MASK_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_LAST = 3'd5;

    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_STEP    = 2'd1,
        FUNC_SPEED   = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    localparam logic [1:0] ROT_FWD  = 2'd0;
    localparam logic [1:0] ROT_REV  = 2'd1;
    localparam logic [1:0] ROT_STOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 2'd2;

    localparam logic [1:0] CH_U = 2'd0;
    localparam logic [1:0] CH_V = 2'd1;
    localparam logic [1:0] CH_W = 2'd2;

    localparam logic [1:0] MUX_U = 2'd0;
    localparam logic [1:0] MUX_V = 2'd1;
    localparam logic [1:0] MUX_W = 2'd3;

    typedef struct packed {
        func_t               func;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [LIMIT_W-1:0]  lock_limit;
        logic [1:0]          rotation;
    } cfg_t;

    typedef struct packed {
        logic [MASK_W-1:0] phase_mask;
        logic [POS_W-1:0]  position;
        logic              closed_loop;
        logic              lock_flag;
        logic              drive_off;
        logic [1:0]        next_channel;
    } result_t;

    // bridge switch enables per commutation step
    function automatic logic [MASK_W-1:0] phase_mask_of(input logic [POS_W-1:0] pos);
        logic [MASK_W-1:0] m;
        case (pos)
            3'd0:    m = 6'h09;
            3'd1:    m = 6'h21;
            3'd2:    m = 6'h24;
            3'd3:    m = 6'h06;
            3'd4:    m = 6'h12;
            3'd5:    m = 6'h18;
            default: m = '0;
        endcase
        return m;
    endfunction

    // expected back-emf pattern, bit0 U, bit1 V, bit2 W
    function automatic logic [2:0] expect_of(input logic reverse, input logic [POS_W-1:0] pos);
        logic [2:0] p;
        if (!reverse) begin
            case (pos)
                3'd0:    p = 3'd6;
                3'd1:    p = 3'd4;
                3'd2:    p = 3'd5;
                3'd3:    p = 3'd1;
                3'd4:    p = 3'd3;
                3'd5:    p = 3'd2;
                default: p = '0;
            endcase
        end
        else begin
            case (pos)
                3'd0:    p = 3'd2;
                3'd1:    p = 3'd6;
                3'd2:    p = 3'd4;
                3'd3:    p = 3'd5;
                3'd4:    p = 3'd1;
                3'd5:    p = 3'd3;
                default: p = '0;
            endcase
        end
        return p;
    endfunction

    function automatic logic [1:0] mux_code_of(input logic [1:0] ch);
        logic [1:0] c;
        case (ch)
            CH_V:    c = MUX_V;
            CH_W:    c = MUX_W;
            default: c = MUX_U;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/sensorless_bldc_commutator_core.sv
// channel  | signals                                   | content
// s_*      | s_tvalid s_tready s_tdata s_tuser         | one command or adc sample
// m_*      | m_tvalid m_tready m_tdata                 | one drive status per command
// cfg_*    | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//
// each command yields exactly one status transaction, through the input and status registers;
// one command per cycle is sustained while m_tready is high
// rate is set by the combinational step logic between the input and status registers
// reset sets threshold 128, lock limit 1000, forward rotation and the lock flag
// a stalled m side holds the status register; s_tready drops once the input register is full
module sensorless_bldc_commutator_core
    import sbldc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] sample
    input  logic [1:0]            s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] phase_mask, [8:6] position, [9] closed_loop, [10] lock_flag,
    // [11] drive_off, [13:12] next_channel, [15:14] zero
    output logic [15:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   item;
    logic    out_free;
    logic    fire;
    result_t result;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= 8'd128;
            cfg_reg.lock_limit <= 16'd1000;
            cfg_reg.rotation   <= ROT_FWD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  cfg_reg.threshold  <= cfg_data[THRESH_W-1:0];
                REG_LOCK_LIMIT: cfg_reg.lock_limit <= cfg_data[LIMIT_W-1:0];
                REG_ROTATION:   cfg_reg.rotation   <= cfg_data[1:0];
                default:        cfg_reg.rotation   <= cfg_reg.rotation;
            endcase
        end
    end

    assign in_item.func   = func_t'(s_tuser);
    assign in_item.sample = s_tdata[SAMPLE_W-1:0];

    assign out_free = !out_valid_reg || m_tready;

    sbldc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    sbldc_step_core u_step_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.next_channel, res_reg.drive_off, res_reg.lock_flag,
                       res_reg.closed_loop, res_reg.position, res_reg.phase_mask};

endmodule

>>> hw/rtl/sbldc_in_stage.sv
module sbldc_in_stage
    import sbldc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  out_free,
    output logic  fire,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign fire     = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hw/rtl/sbldc_step_core.sv
module sbldc_step_core
    import sbldc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [SAMPLE_W-1:0] samp_u_reg, samp_u_next;
    logic [SAMPLE_W-1:0] samp_v_reg, samp_v_next;
    logic [1:0]          ch_reg, ch_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                closed_reg, closed_next;
    logic                speed_reg, speed_next;
    logic                locked_reg, locked_next;
    logic [LIMIT_W-1:0]  miss_reg, miss_next;

    logic [POS_W-1:0]    adv_pos;
    logic                adv_off;
    logic [1:0]          idx;
    logic [1:0]          idx_next;
    logic [SAMPLE_W-1:0] thr;
    logic [2:0]          pat;
    logic                match;
    logic                hit;
    logic                off;

    // one step along the commutation sequence; stop rotation gives step 0 with the drive off
    always_comb
    begin
        adv_off = 1'b0;
        case (cfg.rotation)
            ROT_FWD: adv_pos = (pos_reg >= POS_LAST) ? '0 : pos_reg + 3'd1;
            ROT_REV: adv_pos = (pos_reg == '0 || pos_reg > POS_LAST) ? POS_LAST
                                                                    : pos_reg - 3'd1;
            default:
            begin
                adv_pos = '0;
                adv_off = 1'b1;
            end
        endcase
    end

    assign idx      = (ch_reg > CH_W) ? CH_U : ch_reg;
    assign idx_next = (idx == CH_W) ? CH_U : idx + 2'd1;
    assign thr      = SAMPLE_W'(cfg.threshold);
    // the W sample completes the pattern straight from the input
    assign pat      = {item.sample > thr, samp_v_reg > thr, samp_u_reg > thr};
    assign match    = (cfg.rotation == ROT_FWD || cfg.rotation == ROT_REV)
                   && (pos_reg <= POS_LAST)
                   && (expect_of(cfg.rotation[0], pos_reg) == pat);
    assign hit      = (item.func == FUNC_SAMPLE) && (idx == CH_W) && match && speed_reg;

    always_comb
    begin
        samp_u_next = samp_u_reg;
        samp_v_next = samp_v_reg;
        ch_next     = ch_reg;
        pos_next    = pos_reg;
        closed_next = closed_reg;
        speed_next  = speed_reg;
        locked_next = locked_reg;
        miss_next   = miss_reg;
        off         = 1'b0;
        unique case (item.func)
            FUNC_SAMPLE:
            begin
                if (idx == CH_U)
                begin
                    samp_u_next = item.sample;
                end
                if (idx == CH_V)
                begin
                    samp_v_next = item.sample;
                end
                ch_next = idx_next;
                if (idx == CH_W)
                begin
                    if (match && speed_reg)
                    begin
                        pos_next    = adv_pos;
                        miss_next   = '0;
                        closed_next = 1'b1;
                    end
                    else if (closed_reg)
                    begin
                        if (miss_reg != '1)
                        begin
                            miss_next = miss_reg + 16'd1;
                        end
                        if (cfg.lock_limit < miss_reg)
                        begin
                            locked_next = 1'b1;
                            closed_next = 1'b0;
                            speed_next  = 1'b0;
                            off         = 1'b1;
                        end
                    end
                end
            end
            FUNC_STEP:
            begin
                if (!locked_reg && !closed_reg)
                begin
                    pos_next = adv_pos;
                    off      = adv_off;
                end
            end
            FUNC_SPEED:
            begin
                speed_next = 1'b1;
            end
            FUNC_RESTART:
            begin
                if (locked_reg)
                begin
                    pos_next    = '0;
                    locked_next = 1'b0;
                end
            end
            default:
            begin
                off = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.phase_mask   = phase_mask_of(pos_next);
        result.position     = pos_next;
        result.closed_loop  = closed_next;
        result.lock_flag    = locked_next;
        result.drive_off    = off;
        result.next_channel = mux_code_of(ch_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_u_reg <= '0;
            samp_v_reg <= '0;
            ch_reg     <= CH_U;
            pos_reg    <= '0;
            closed_reg <= 1'b0;
            speed_reg  <= 1'b0;
            locked_reg <= 1'b1;
            miss_reg   <= '0;
        end
        else if (fire)
        begin
            samp_u_reg <= samp_u_next;
            samp_v_reg <= samp_v_next;
            ch_reg     <= ch_next;
            pos_reg    <= pos_next;
            closed_reg <= closed_next;
            speed_reg  <= speed_next;
            locked_reg <= locked_next;
            miss_reg   <= miss_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("commutation step out of range");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg != 2'd3)
        else $error("channel index out of range");

    a_hit_clears_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && hit) |=> (miss_reg == '0 && closed_reg))
        else $error("pattern match did not clear miss counter");

    a_off_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && off) |=> (locked_reg || pos_reg == '0))
        else $error("drive off without lock or stop");

    a_lock_leaves_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !locked_reg && locked_next) |=> (!closed_reg && !speed_reg))
        else $error("lock did not leave closed loop");

endmodule

>>> test/sensorless_bldc_commutator_core_tb.sv
`timescale 1ns / 100ps

module sensorless_bldc_commutator_core_tb;
    import sbldc_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1800;

    // switch masks per step, step 0 in the low bits
    localparam logic [35:0] MASK_BY_STEP = {6'h18, 6'h12, 6'h06, 6'h24, 6'h21, 6'h09};
    // back-emf pattern per step (bit0 U, bit1 V, bit2 W), step 0 in the low bits
    localparam logic [17:0] FWD_BEMF = {3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd6};
    localparam logic [17:0] REV_BEMF = {3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2};

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

    typedef struct packed {
        logic [5:0] phase_mask;
        logic [2:0] position;
        logic       closed_loop;
        logic       lock_flag;
        logic       drive_off;
        logic [1:0] next_channel;
    } drive_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] sample
    logic [1:0]            s_tuser;   // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    // [5:0] phase_mask, [8:6] position, [9] closed_loop, [10] lock_flag,
    // [11] drive_off, [13:12] next_channel, [15:14] zero
    logic [15:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // commutator state as the testbench sees it
    logic [7:0]    thr_q;
    logic [15:0]   limit_q;
    logic [1:0]    rot_q;
    logic [7:0]    phase_v [3];
    logic [1:0]    chan_idx;
    logic [2:0]    pos_q;
    logic          closed_q;
    logic          speed_q;
    logic          locked_q;
    logic [15:0]   miss_q;
    drive_status_t status_q [$];
    drive_status_t want;

    int          mismatches   = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    bit          idle_en      = 1'b1;
    int          quiet_cycles = 0;
    int unsigned stall_cyc    = 0;
    rx_mode_t    stall_mode   = RX_FREE;

    sensorless_bldc_commutator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [2:0] bemf_target(input logic [1:0] rot, input logic [2:0] pos);
        return (rot == ROT_REV) ? REV_BEMF[pos*3 +: 3] : FWD_BEMF[pos*3 +: 3];
    endfunction

    // one commutation step in the configured direction, 1 when the drive goes off
    function automatic logic step_once();
        logic off;
        off = 1'b0;
        if (rot_q == ROT_FWD)
            pos_q = (pos_q >= POS_LAST) ? 3'd0 : pos_q + 3'd1;
        else if (rot_q == ROT_REV)
            pos_q = (pos_q == 3'd0 || pos_q > POS_LAST) ? POS_LAST : pos_q - 3'd1;
        else
        begin
            pos_q = 3'd0;
            off = 1'b1;
        end
        return off;
    endfunction

    function automatic logic check_bemf();
        logic [2:0] pat;
        logic       over;
        logic       off;
        pat = {phase_v[2] > thr_q, phase_v[1] > thr_q, phase_v[0] > thr_q};
        off = 1'b0;
        if ((rot_q == ROT_FWD || rot_q == ROT_REV) && pat == bemf_target(rot_q, pos_q)
            && speed_q)
        begin
            off = step_once();
            miss_q = '0;
            closed_q = 1'b1;
        end
        else if (closed_q)
        begin
            // compare first, then count; the counter saturates
            over = limit_q < miss_q;
            if (miss_q != 16'hFFFF)
                miss_q = miss_q + 16'd1;
            if (over)
            begin
                locked_q = 1'b1;
                closed_q = 1'b0;
                speed_q = 1'b0;
                off = 1'b1;
            end
        end
        return off;
    endfunction

    task automatic advance_commutation(input func_t f, input logic [7:0] smp);
        drive_status_t st;
        logic          off;
        off = 1'b0;
        case (f)
            FUNC_SAMPLE:
            begin
                phase_v[chan_idx] = smp;
                chan_idx = (chan_idx == CH_W) ? CH_U : chan_idx + 2'd1;
                if (chan_idx == CH_U)
                    off = check_bemf();
            end
            FUNC_STEP:
            begin
                if (!locked_q && !closed_q)
                    off = step_once();
            end
            FUNC_SPEED:
                speed_q = 1'b1;
            default:
            begin
                if (locked_q)
                begin
                    pos_q = 3'd0;
                    locked_q = 1'b0;
                end
            end
        endcase
        st.phase_mask  = MASK_BY_STEP[pos_q*6 +: 6];
        st.position    = pos_q;
        st.closed_loop = closed_q;
        st.lock_flag   = locked_q;
        st.drive_off   = off;
        case (chan_idx)
            CH_V:    st.next_channel = MUX_V;
            CH_W:    st.next_channel = MUX_W;
            default: st.next_channel = MUX_U;
        endcase
        status_q.push_back(st);
    endtask

    task automatic send_cmd(input func_t f, input logic [7:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            if (idle_en)
            begin
                gap = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 8) : $urandom_range(4, 1);
                s_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        advance_commutation(f, smp);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD:  thr_q = val[7:0];
            REG_LOCK_LIMIT: limit_q = val;
            REG_ROTATION:   rot_q = val[1:0];
            default:        ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [15:0] lim,
                              input logic [1:0] rot);
        wait_idle();
        write_reg(REG_THRESHOLD, {8'h00, thr});
        write_reg(REG_LOCK_LIMIT, lim);
        write_reg(REG_ROTATION, {14'd0, rot});
        cfg_valid <= 1'b0;
    endtask

    // realign to the U sample, then send U, V, W on either side of the threshold
    task automatic bemf_triple(input logic matching);
        logic [2:0] pat;
        logic [7:0] smp;
        while (chan_idx != CH_U)
            send_cmd(FUNC_SAMPLE, 8'($urandom));
        pat = 3'($urandom);
        if (matching && (rot_q == ROT_FWD || rot_q == ROT_REV))
            pat = bemf_target(rot_q, pos_q);
        for (int ph = 0; ph < 3; ph++)
        begin
            if (!pat[ph])
                smp = 8'($urandom_range(thr_q, 0));
            else if (thr_q == 8'hFF)
                smp = 8'hFF;
            else
                smp = 8'($urandom_range(255, thr_q + 1));
            send_cmd(FUNC_SAMPLE, smp);
        end
    endtask

    task automatic test_startup();
        send_cmd(FUNC_STEP, 8'hFF);      // locked out of reset
        send_cmd(FUNC_RESTART, 8'h00);
        send_cmd(FUNC_RESTART, 8'hA5);   // no lock to clear
        repeat (6)
            send_cmd(FUNC_STEP, 8'h5A);  // full forward turn, wraps after step 5
        send_cmd(FUNC_SPEED, 8'h00);
    endtask

    task automatic test_closed_loop_entry();
        // step 0 forward wants V and W high
        send_cmd(FUNC_SAMPLE, 8'h00);
        send_cmd(FUNC_SAMPLE, 8'hFF);
        send_cmd(FUNC_SAMPLE, 8'hFF);
        send_cmd(FUNC_STEP, 8'h00);      // ignored in closed loop
    endtask

    task automatic test_lock();
        // nothing is above threshold 255, so every check misses
        set_config(8'hFF, 16'd0, ROT_FWD);
        repeat (2)
        begin
            send_cmd(FUNC_SAMPLE, 8'hFF);
            send_cmd(FUNC_SAMPLE, 8'h80);
            send_cmd(FUNC_SAMPLE, 8'hFF);
        end
        send_cmd(FUNC_RESTART, 8'hFF);
    endtask

    task automatic test_stop();
        set_config(8'h00, 16'hFFFE, ROT_STOP);
        send_cmd(FUNC_STEP, 8'h01);
    endtask

    task automatic test_reverse();
        set_config(8'd128, 16'd1000, ROT_REV);
        send_cmd(FUNC_STEP, 8'h00);      // reverse wraps from step 0 to step 5
        send_cmd(FUNC_SPEED, 8'h00);
        // W equal to the threshold still counts as low
        send_cmd(FUNC_SAMPLE, 8'h81);
        send_cmd(FUNC_SAMPLE, 8'hC0);
        send_cmd(FUNC_SAMPLE, 8'h80);
    endtask

    task automatic test_random_runs();
        int          first;
        logic [7:0]  thr;
        logic [15:0] lim;
        logic [1:0]  rot;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            case ($urandom_range(7, 0))
                0:       thr = 8'h00;
                1:       thr = 8'hFF;
                default: thr = 8'($urandom);
            endcase
            if ($urandom_range(3, 0) == 0)
                lim = 16'($urandom_range(65534, 0));
            else
                lim = 16'($urandom_range(6, 0));
            if ($urandom_range(9, 0) == 0)
                rot = ROT_STOP;
            else
                rot = ($urandom_range(1, 0) == 0) ? ROT_FWD : ROT_REV;
            set_config(thr, lim, rot);
            idle_en = ($urandom_range(3, 0) != 0);

            if (locked_q)
                send_cmd(FUNC_RESTART, 8'($urandom));
            repeat ($urandom_range(3, 0))
                send_cmd(FUNC_STEP, 8'($urandom));
            if ($urandom_range(7, 0) != 0)
                send_cmd(FUNC_SPEED, 8'($urandom));
            repeat ($urandom_range(24, 4))
            begin
                case ($urandom_range(9, 0))
                    0:
                        send_cmd(func_t'($urandom_range(3, 0)), 8'($urandom));
                    1, 2:
                        bemf_triple(1'b0);
                    3:
                    begin
                        if (locked_q)
                        begin
                            send_cmd(FUNC_RESTART, 8'($urandom));
                            send_cmd(FUNC_SPEED, 8'($urandom));
                        end
                        else
                            send_cmd(FUNC_STEP, 8'($urandom));
                    end
                    default:
                        bemf_triple(1'b1);
                endcase
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status transaction with nothing outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                check_field("phase_mask", want.phase_mask, m_tdata[5:0]);
                check_field("position", want.position, m_tdata[8:6]);
                check_field("closed_loop", want.closed_loop, m_tdata[9]);
                check_field("lock_flag", want.lock_flag, m_tdata[10]);
                check_field("drive_off", want.drive_off, m_tdata[11]);
                check_field("next_channel", want.next_channel, m_tdata[13:12]);
            end
        end
    end

    // receiver backpressure under a randomly redrawn stall mode
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 64 == 0)
            stall_mode <= rx_mode_t'($urandom_range(3, 0));
        case (stall_mode)
            RX_FREE:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(3, 0) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(3, 0) == 0);
            default:  m_tready <= (stall_cyc % 16 < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= FUNC_SAMPLE;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= '0;

        thr_q      = 8'd128;
        limit_q    = 16'd1000;
        rot_q      = ROT_FWD;
        phase_v[0] = 8'h00;
        phase_v[1] = 8'h00;
        phase_v[2] = 8'h00;
        chan_idx   = CH_U;
        pos_q      = 3'd0;
        closed_q   = 1'b0;
        speed_q    = 1'b0;
        locked_q   = 1'b1;
        miss_q     = 16'd0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup();
        test_closed_loop_entry();
        test_lock();
        test_stop();
        test_reverse();
        test_random_runs();
        wait_idle();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sbldc_pkg.sv
hw/rtl/sbldc_in_stage.sv
hw/rtl/sbldc_step_core.sv
hw/rtl/sensorless_bldc_commutator_core.sv
test/sensorless_bldc_commutator_core_tb.sv
